[src/sfrx_pkg.sv]
// ----------------------------------------------------------------------------
// sfrx_pkg
// shared types and constants of the sync framed receiver
// ----------------------------------------------------------------------------
package sfrx_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned STORE_DEPTH = 5;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned ADDR_W      = 4;
  localparam int unsigned PDATA_W     = 32;

  localparam logic [CNT_W-1:0] LAST_STORE = CNT_W'(STORE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CHECK_CNT  = CNT_W'(STORE_DEPTH);

  // register indexes
  localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] REG_SYNC_THIRD  = 2'd2;

  typedef enum logic [3:0] {
    PH_FIRST   = 4'b0001,
    PH_SECOND  = 4'b0010,
    PH_THIRD   = 4'b0100,
    PH_COLLECT = 4'b1000
  } sfrx_phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] sync_first;
    logic [BYTE_W-1:0] sync_second;
    logic [BYTE_W-1:0] sync_third;
  } sfrx_cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_cmd;
    logic [DATA_W-1:0] frame_data;
    logic [BYTE_W-1:0] computed_sum;
    logic              sum_ok;
  } sfrx_res_t;

  typedef struct packed {
    logic collect;
    logic emit;
    logic go;
  } sfrx_stat_t;

endpackage

[src/sfrx_cfg.sv]
// ----------------------------------------------------------------------------
// sfrx_cfg
// apb register file holding the three sync bytes
// ----------------------------------------------------------------------------
module sfrx_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfrx_pkg::ADDR_W-1:0] paddr,
  input  logic [sfrx_pkg::PDATA_W-1:0] pwdata,
  output logic [sfrx_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output sfrx_pkg::sfrx_cfg_t         cfg
);
  import sfrx_pkg::*;

  logic [BYTE_W-1:0] first_r, second_r, third_r;
  logic              wr_en;
  logic [1:0]        idx;

  assign idx    = paddr[3:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= '0;
      second_r <= '0;
      third_r  <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_SYNC_FIRST:  first_r  <= pwdata[BYTE_W-1:0];
        REG_SYNC_SECOND: second_r <= pwdata[BYTE_W-1:0];
        REG_SYNC_THIRD:  third_r  <= pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SYNC_FIRST:  prdata = PDATA_W'(first_r);
      REG_SYNC_SECOND: prdata = PDATA_W'(second_r);
      REG_SYNC_THIRD:  prdata = PDATA_W'(third_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg.sync_first  = first_r;
  assign cfg.sync_second = second_r;
  assign cfg.sync_third  = third_r;

endmodule

[src/sfrx_core.sv]
// ----------------------------------------------------------------------------
// sfrx_core
// input register, sync hunt, payload store and frame check
// ----------------------------------------------------------------------------
module sfrx_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sfrx_pkg::sfrx_cfg_t        cfg,
  input  logic                       in_valid,
  input  logic [sfrx_pkg::BYTE_W-1:0] in_rx_byte,
  output logic                       in_stall,
  input  logic                       res_take,
  output logic                       res_valid,
  output sfrx_pkg::sfrx_res_t        res,
  output sfrx_pkg::sfrx_stat_t       stat
);
  import sfrx_pkg::*;

  logic                  s1_valid_r;
  logic [BYTE_W-1:0]     s1_byte_r;
  sfrx_phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [BYTE_W-1:0]     store_r [STORE_DEPTH];
  logic                  emit, go, step, store_wr;
  logic [BYTE_W-1:0]     sum;

  assign emit     = s1_valid_r && (phase_r == PH_COLLECT) && (cnt_r == CHECK_CNT);
  assign go       = !emit || res_take;
  assign step     = s1_valid_r && go;
  assign in_stall = s1_valid_r && !go;
  assign store_wr = step && (phase_r == PH_COLLECT) && (cnt_r <= LAST_STORE);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    case (phase_r)
      PH_FIRST: begin
        if (s1_byte_r == cfg.sync_first) phase_nxt = PH_SECOND;
      end
      PH_SECOND: begin
        phase_nxt = (s1_byte_r == cfg.sync_second) ? PH_THIRD : PH_FIRST;
      end
      PH_THIRD: begin
        phase_nxt = (s1_byte_r == cfg.sync_third) ? PH_COLLECT : PH_FIRST;
        cnt_nxt   = '0;
      end
      PH_COLLECT: begin
        if (cnt_r <= LAST_STORE) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end else begin
          cnt_nxt   = '0;
          phase_nxt = PH_FIRST;
        end
      end
      default: begin
        phase_nxt = PH_FIRST;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      cnt_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_wr) begin
      store_r[cnt_r] <= s1_byte_r;
    end
  end

  assign sum = store_r[0] ^ store_r[1] ^ store_r[2] ^ store_r[3] ^ store_r[4];

  assign res_valid        = emit;
  assign res.frame_cmd    = store_r[0];
  assign res.frame_data   = {store_r[4], store_r[3], store_r[2], store_r[1]};
  assign res.computed_sum = sum;
  assign res.sum_ok       = (sum == s1_byte_r);

  assign stat.collect = (phase_r == PH_COLLECT);
  assign stat.emit    = emit;
  assign stat.go      = go;

endmodule

[src/sfrx_out.sv]
// ----------------------------------------------------------------------------
// sfrx_out
// result register between the frame check and the output channel
// ----------------------------------------------------------------------------
module sfrx_out (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid,
  input  sfrx_pkg::sfrx_res_t res,
  output logic                res_take,
  output logic                out_valid,
  input  logic                out_stall,
  output sfrx_pkg::sfrx_res_t out_res
);
  import sfrx_pkg::*;

  logic      valid_r;
  sfrx_res_t res_r;

  assign res_take = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_take) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

[src/sync_framed_receiver_xor_check.sv]
// ----------------------------------------------------------------------------
// sync_framed_receiver_xor_check
// hunts for a three byte sync word, collects command, data and checksum,
// and emits each frame with its xor sum and a checksum flag
// path: a byte is registered, checked and its frame result registered, so a
//   frame reaches out_valid via the input register and the result register
// throughput: one byte per cycle unless stalled, set by the single check stage
// reset: rst_n low clears sync registers, hunt state and both valid bits
// ----------------------------------------------------------------------------
module sync_framed_receiver_xor_check (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sfrx_pkg::ADDR_W-1:0]  paddr,
  input  logic [sfrx_pkg::PDATA_W-1:0] pwdata,
  output logic [sfrx_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sfrx_pkg::BYTE_W-1:0]  in_rx_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sfrx_pkg::BYTE_W-1:0]  out_frame_cmd,
  output logic [sfrx_pkg::DATA_W-1:0]  out_frame_data,
  output logic [sfrx_pkg::BYTE_W-1:0]  out_computed_sum,
  output logic                         out_sum_ok
);
  import sfrx_pkg::*;

  sfrx_cfg_t  cfg;
  sfrx_res_t  res, out_res;
  sfrx_stat_t stat;
  logic       res_valid, res_take;

  sfrx_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sfrx_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_stall   (in_stall),
    .res_take   (res_take),
    .res_valid  (res_valid),
    .res        (res),
    .stat       (stat)
  );

  sfrx_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_frame_cmd    = out_res.frame_cmd;
  assign out_frame_data   = out_res.frame_data;
  assign out_computed_sum = out_res.computed_sum;
  assign out_sum_ok       = out_res.sum_ok;

  // a frame is only emitted while collecting payload
  a_emit_collect: assert property (@(posedge clk) disable iff (!rst_n)
    stat.emit |-> stat.collect)
    else $error("frame emitted outside payload collection");

  // a delivered frame sends the hunt back to the first sync byte
  a_emit_rehunt: assert property (@(posedge clk) disable iff (!rst_n)
    stat.emit && stat.go |=> !stat.collect)
    else $error("hunt did not restart after frame");

  // an emitted frame always lands in the result register
  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    stat.emit && stat.go |=> out_valid)
    else $error("emitted frame lost");

  // input side only holds off while a frame waits on a full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> stat.emit && out_valid && out_stall)
    else $error("input stalled without a blocked frame");

endmodule
